[hdl/dtbl_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// dtbl_pkg
// Shared types and constants of the dual token bucket limiter.
// -----------------------------------------------------------------------------
package dtbl_pkg;

    // Field widths
    localparam int unsigned OP_W    = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MS_W    = 10;   // elapsed times below one second
    localparam int unsigned RQ_W    = 23;   // rate / 1000
    localparam int unsigned RR_W    = 10;   // rate % 1000
    localparam int unsigned PY_W    = RR_W + MS_W;
    localparam int unsigned QD_W    = 11;   // (rate % 1000) * elapsed / 1000

    // Reset rate, 10 MiB/s
    localparam logic [DATA_W-1:0] RATE_RESET = 32'd10485760;
    localparam logic [MS_W-1:0]   MS_PER_S   = 10'd1000;

    // x / 1000 == (x >> 3) / 125, done as a multiply by a rounded-up reciprocal.
    // Rate path: 29-bit dividend, shift 36.
    localparam logic [29:0] RQ_MUL   = 30'd549755814;
    localparam int unsigned RQ_SHIFT = 36;
    // Fraction path: 17-bit dividend, shift 24.
    localparam logic [17:0] RD_MUL   = 18'd134218;
    localparam int unsigned RD_SHIFT = 24;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CHECK_TX  = 3'd0;
    localparam logic [OP_W-1:0] OP_CHECK_RX  = 3'd1;
    localparam logic [OP_W-1:0] OP_RECORD_TX = 3'd2;
    localparam logic [OP_W-1:0] OP_RECORD_RX = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    // One accepted request
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] now;
        logic [DATA_W-1:0] n;
    } item_t;

    // Request with its refill amount worked out
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] n;
        logic              refill;  // refill both buckets
        logic              full;    // a second or more has passed: fill to capacity
        logic [DATA_W-1:0] add;     // tokens to add when not full
    } refill_t;

    // Bucket state after one request
    typedef struct packed {
        logic              allowed;
        logic [DATA_W-1:0] tx;
        logic [DATA_W-1:0] rx;
    } bucket_t;

endpackage
`default_nettype wire

[hdl/dtbl_refill.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// dtbl_refill
// Input register and the refill-amount pipeline: elapsed time, rate * elapsed
// split into whole and fractional thousandths, divide by 1000.
// -----------------------------------------------------------------------------
module dtbl_refill (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire dtbl_pkg::item_t             in_item,
    input  wire logic [dtbl_pkg::RQ_W-1:0]   rq,
    input  wire logic [dtbl_pkg::RR_W-1:0]   rr,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output dtbl_pkg::refill_t                out_refill
);
    import dtbl_pkg::*;

    item_t             s0_reg;
    refill_t           s1_reg, s2_reg, s3_reg, s4_reg;
    logic              v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic              rdy0, rdy1, rdy2, rdy3, rdy4;
    logic [DATA_W-1:0] last_reg;

    logic [MS_W-1:0]   e1_reg;
    logic [DATA_W-1:0] pq2_reg, pq3_reg;
    logic [PY_W-1:0]   py2_reg;
    logic [QD_W-1:0]   qd3_reg;

    logic [DATA_W-1:0]      elapsed;
    logic                   s0_active;
    logic [RQ_W+MS_W-1:0]   pq_full;
    logic [PY_W-1:0]        py_full;
    logic [PY_W-3+17:0]     qd_prod;

    // A stage takes new data when it is empty or the next one moves on
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    assign elapsed   = s0_reg.now - last_reg;
    assign s0_active = (s0_reg.op <= OP_RECORD_RX);

    assign pq_full = rq * e1_reg;
    assign py_full = rr * e1_reg;
    assign qd_prod = py2_reg[PY_W-1:3] * RD_MUL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            last_reg <= '0;
        end else begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            // every check or record leaves now as the last refill time
            if (rdy1 && v0_reg && s0_active) begin
                last_reg <= s0_reg.now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && in_valid) begin
            s0_reg <= in_item;
        end
        if (rdy1 && v0_reg) begin
            s1_reg.op     <= s0_reg.op;
            s1_reg.n      <= s0_reg.n;
            s1_reg.refill <= s0_active && (elapsed != '0);
            s1_reg.full   <= (elapsed >= DATA_W'(MS_PER_S));
            s1_reg.add    <= '0;
            e1_reg        <= elapsed[MS_W-1:0];
        end
        if (rdy2 && v1_reg) begin
            s2_reg  <= s1_reg;
            pq2_reg <= pq_full[DATA_W-1:0];
            py2_reg <= py_full;
        end
        if (rdy3 && v2_reg) begin
            s3_reg  <= s2_reg;
            pq3_reg <= pq2_reg;
            qd3_reg <= qd_prod[RD_SHIFT+QD_W-1:RD_SHIFT];
        end
        if (rdy4 && v3_reg) begin
            s4_reg.op     <= s3_reg.op;
            s4_reg.n      <= s3_reg.n;
            s4_reg.refill <= s3_reg.refill;
            s4_reg.full   <= s3_reg.full;
            s4_reg.add    <= pq3_reg + DATA_W'(qd3_reg);
        end
    end

    assign out_valid  = v4_reg;
    assign out_refill = s4_reg;

endmodule
`default_nettype wire

[hdl/dtbl_bucket.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// dtbl_bucket
// Transmit and receive token state: refill, check and record for one request
// a cycle while the output register is empty or its result is taken.
// -----------------------------------------------------------------------------
module dtbl_bucket (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [dtbl_pkg::DATA_W-1:0]   rate,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dtbl_pkg::refill_t             in_refill,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dtbl_pkg::bucket_t                  out_bucket
);
    import dtbl_pkg::*;

    logic [DATA_W-1:0] tx_reg, rx_reg;
    logic [DATA_W-1:0] tx_fill, rx_fill, tx_next, rx_next;
    logic              allowed;
    bucket_t           out_reg;
    logic              out_valid_reg;

    function automatic logic [DATA_W-1:0] refill_one(
        input logic [DATA_W-1:0] tok,
        input logic [DATA_W-1:0] add,
        input logic [DATA_W-1:0] cap,
        input logic              full
    );
        logic [DATA_W:0] sum;
        sum = {1'b0, tok} + {1'b0, add};
        if (full || (sum > {1'b0, cap})) begin
            refill_one = cap;
        end else begin
            refill_one = sum[DATA_W-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] take_tokens(
        input logic [DATA_W-1:0] tok,
        input logic [DATA_W-1:0] n
    );
        take_tokens = (tok >= n) ? (tok - n) : '0;
    endfunction

    always_comb begin
        tx_fill = in_refill.refill ? refill_one(tx_reg, in_refill.add, rate, in_refill.full)
                                   : tx_reg;
        rx_fill = in_refill.refill ? refill_one(rx_reg, in_refill.add, rate, in_refill.full)
                                   : rx_reg;
        tx_next = tx_fill;
        rx_next = rx_fill;
        allowed = 1'b0;
        case (in_refill.op)
            OP_CHECK_TX:  allowed = (tx_fill >= in_refill.n);
            OP_CHECK_RX:  allowed = (rx_fill >= in_refill.n);
            OP_RECORD_TX: tx_next = take_tokens(tx_fill, in_refill.n);
            OP_RECORD_RX: rx_next = take_tokens(rx_fill, in_refill.n);
            default:      allowed = 1'b0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg        <= RATE_RESET;
            rx_reg        <= RATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) out_valid_reg <= in_valid;
            if (in_ready && in_valid) begin
                tx_reg <= tx_next;
                rx_reg <= rx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_reg.allowed <= allowed;
            out_reg.tx      <= tx_next;
            out_reg.rx      <= rx_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bucket = out_reg;

endmodule
`default_nettype wire

[hdl/dual_token_bucket_limiter_core.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// dual_token_bucket_limiter_core
// Transmit and receive token buckets sharing one byte-per-second rate.
// -----------------------------------------------------------------------------
// Pipeline: input register, four refill stages, bucket stage, result register.
// Throughput: one request per cycle unless m_tready stalls the result register;
//   the token update closes its loop within the bucket stage.
// Reset (aresetn low, synchronous): rate and both buckets go to 10485760,
//   last refill time to 0, all pipeline stages empty.
// A rate write reaches rate_reg, then rq_reg, then the remainder rr_reg.
// -----------------------------------------------------------------------------
module dual_token_bucket_limiter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: rate_bytes_per_second
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] now_ms, [63:32] byte_count
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [0] allowed, [32:1] tx_used, [64:33] rx_used
);
    import dtbl_pkg::*;

    // Rate register and its split into whole thousandths and remainder
    logic [DATA_W-1:0]          rate_reg;
    logic [RQ_W-1:0]            rq_reg;
    logic [RR_W-1:0]            rr_reg;
    logic [58:0]                rq_prod;
    logic [RQ_W+MS_W-1:0]       rq_x1000;
    logic [DATA_W-1:0]          rr_full;

    item_t   in_item;
    logic    rf_valid, rf_ready;
    refill_t rf_item;
    logic    bk_valid, bk_ready;
    bucket_t bk_item;

    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;
    logic [DATA_W-1:0] tx_used, rx_used;

    function automatic logic [DATA_W-1:0] used_of(
        input logic [DATA_W-1:0] cap,
        input logic [DATA_W-1:0] tok
    );
        // saturate at zero while the tokens sit above a lowered rate
        used_of = (cap > tok) ? (cap - tok) : '0;
    endfunction

    // Hold the rate; the user must change it only while no request is in flight, unchecked here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_wr_en) begin
            rate_reg <= cfg_wr_data;
        end
    end

    // rate / 1000 by reciprocal multiply, then the remainder from the registered quotient
    assign rq_prod  = rate_reg[DATA_W-1:3] * RQ_MUL;
    assign rq_x1000 = rq_reg * MS_PER_S;
    assign rr_full  = rate_reg - rq_x1000[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        rq_reg <= rq_prod[RQ_SHIFT+RQ_W-1:RQ_SHIFT];
        rr_reg <= rr_full[RR_W-1:0];
    end

    // Unpack the request
    assign in_item.op  = s_tuser;
    assign in_item.now = s_tdata[31:0];
    assign in_item.n   = s_tdata[63:32];

    // Register the request, find elapsed time, compute the refill amount
    dtbl_refill u_refill (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .rq         (rq_reg),
        .rr         (rr_reg),
        .out_valid  (rf_valid),
        .out_ready  (rf_ready),
        .out_refill (rf_item)
    );

    // Apply refill, check or record to the bucket state
    dtbl_bucket u_bucket (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rate       (rate_reg),
        .in_valid   (rf_valid),
        .in_ready   (rf_ready),
        .in_refill  (rf_item),
        .out_valid  (bk_valid),
        .out_ready  (bk_ready),
        .out_bucket (bk_item)
    );

    // Result register: turn token counts into usage; advance when empty or taken
    assign tx_used  = used_of(rate_reg, bk_item.tx);
    assign rx_used  = used_of(rate_reg, bk_item.rx);
    assign bk_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (bk_ready) begin
            m_tvalid_reg <= bk_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (bk_ready && bk_valid) begin
            m_tdata_reg <= {7'b0, rx_used, tx_used, bk_item.allowed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // With the result register empty, every stage can move, so a request is taken
    a_ready_when_drained: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready
    ) else $error("request refused while the result register is empty");

    // Once rate_reg has held through rq_reg and rr_reg, quotient and remainder rebuild it
    a_rate_split: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (($past(rate_reg) == rate_reg) && ($past(rate_reg, 2) == rate_reg))
        |-> ((33'(rq_x1000) + 33'(rr_reg) == {1'b0, rate_reg}) && (rr_reg < MS_PER_S))
    ) else $error("rate / 1000 split is wrong");

endmodule
`default_nettype wire

[verif/dual_token_bucket_limiter_core_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dual_token_bucket_limiter_core_tb
// Self-checking regression for the transmit/receive token bucket limiter.
// -----------------------------------------------------------------------------
// A directed table covers the field extremes, every operation, the unused
// operation codes, zero elapsed time, backward (wrapping) timestamps and a
// rate lowered below the current tokens. Random phases follow, each at its own
// rate (reset, zero, one, around 1000, all ones, random). Every accepted request runs
// through a bucket predictor kept in this file, and each result is compared
// field by field with the oldest expected verdict. Both channels idle at
// random, in stretches, and the rate is only rewritten once the pipe is empty.
// -----------------------------------------------------------------------------
module dual_token_bucket_limiter_core_tb;
    import dtbl_pkg::*;

    localparam int          CLK_HALF       = 4;
    localparam int          RESET_CYCLES   = 5;
    localparam int          CFG_SETTLE     = 3;     // rate / 1000 settles via rq_reg, then rr_reg
    localparam int          TAIL_CYCLES    = 12;    // pipe latency plus margin
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PROBE_N        = 26;
    localparam int          PHASE_N        = 10;
    localparam int          PHASE_ITEMS    = 195;
    localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;
    localparam logic [31:0] MS_PER_SEC     = 32'd1000;

    // One directed row: either a rate write (rate in nbytes) or a request,
    // optionally carrying a hand-typed expected verdict.
    typedef struct packed {
        bit          is_cfg;
        bit          typed;
        logic [2:0]  op;
        logic [31:0] now_ms;
        logic [31:0] nbytes;
        logic        allowed;
        logic [31:0] tx_used;
        logic [31:0] rx_used;
    } probe_row_t;

    typedef struct packed {
        logic        allowed;
        logic [31:0] tx_used;
        logic [31:0] rx_used;
    } verdict_t;

    // DUT signals; the driven ones are known from time zero
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;      // [31:0] now_ms, [63:32] byte_count
    logic [2:0]  s_tuser     = '0;      // [2:0] operation
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;               // [0] allowed, [32:1] tx_used, [64:33] rx_used

    // Bucket predictor state
    logic [31:0] bkt_rate = RATE_RESET;
    logic [31:0] bkt_tx   = RATE_RESET;
    logic [31:0] bkt_rx   = RATE_RESET;
    logic [31:0] bkt_last = '0;

    verdict_t    verdict_q [$];
    probe_row_t  probes [0:PROBE_N-1];
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_count   = 0;
    bit          sender_lazy  = 1'b1;

    dual_token_bucket_limiter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Clamp a bucket refill at the rate, which is also the capacity.
    function automatic logic [31:0] bucket_fill(input logic [31:0] tokens,
                                                input logic [63:0] grant);
        logic [63:0] sum;
        sum = {32'd0, tokens} + grant;
        return (sum > {32'd0, bkt_rate}) ? bkt_rate : sum[31:0];
    endfunction

    function automatic logic [31:0] bucket_usage(input logic [31:0] tokens);
        return (bkt_rate > tokens) ? bkt_rate - tokens : 32'd0;
    endfunction

    // Advance both buckets by one request and return the verdict it yields.
    function automatic verdict_t limiter_step(input logic [2:0] op,
                                              input logic [31:0] now_ms,
                                              input logic [31:0] nbytes);
        logic [31:0] elapsed;
        logic [63:0] grant;
        verdict_t    v;
        v.allowed = 1'b0;
        elapsed   = now_ms - bkt_last;
        if (op <= OP_RECORD_RX) begin
            // Refill only when time has moved; a backward stamp wraps to a long gap
            if (elapsed != 32'd0) begin
                grant    = ({32'd0, bkt_rate} * {32'd0, elapsed}) / {32'd0, MS_PER_SEC};
                bkt_tx   = bucket_fill(bkt_tx, grant);
                bkt_rx   = bucket_fill(bkt_rx, grant);
                bkt_last = now_ms;
            end
            case (op)
                OP_CHECK_TX:  v.allowed = (bkt_tx >= nbytes);
                OP_CHECK_RX:  v.allowed = (bkt_rx >= nbytes);
                OP_RECORD_TX: bkt_tx = (bkt_tx >= nbytes) ? bkt_tx - nbytes : 32'd0;
                default:      bkt_rx = (bkt_rx >= nbytes) ? bkt_rx - nbytes : 32'd0;
            endcase
        end
        v.tx_used = bucket_usage(bkt_tx);
        v.rx_used = bucket_usage(bkt_rx);
        return v;
    endfunction

    // Drive one request (random gap while lazy), hold it until accepted, then queue
    // its expected verdict (the typed one where the row supplies it).
    task automatic push_request(input logic [2:0] op, input logic [31:0] now_ms,
                                input logic [31:0] nbytes, input bit typed,
                                input verdict_t typed_v);
        int unsigned gap;
        verdict_t    v;
        gap = sender_lazy ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {nbytes, now_ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = limiter_step(op, now_ms, nbytes);
        verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
        sent_count++;
        // Switch between idling and back-to-back stretches
        if (sent_count % 50 == 0)
            sender_lazy = ($urandom_range(0, 2) != 0);
    endtask

    // Hold the request channel until every expected verdict has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_rate(input logic [31:0] rate);
        drain_results();
        cfg_wr_data <= rate;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bkt_rate   = rate;
        // Let the derived rate / 1000 terms settle before the next request
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    // Result side: stall at random, then compare each accepted result with
    // the oldest queued verdict.
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          lazy;
        verdict_t    want;
        verdict_t    got;
        taken = 0;
        lazy  = 1'b1;
        forever begin
            stall = lazy ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33]};
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, got.allowed, got.tx_used, got.rx_used);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (got.allowed !== want.allowed) begin
                    $display("%0t: allowed mismatch, expected %0d, actual %0d",
                             $time, want.allowed, got.allowed);
                    fail_count++;
                end
                if (got.tx_used !== want.tx_used) begin
                    $display("%0t: tx_used mismatch, expected %0d, actual %0d",
                             $time, want.tx_used, got.tx_used);
                    fail_count++;
                end
                if (got.rx_used !== want.rx_used) begin
                    $display("%0t: rx_used mismatch, expected %0d, actual %0d",
                             $time, want.rx_used, got.rx_used);
                    fail_count++;
                end
            end
            taken++;
            if (taken % 40 == 0)
                lazy = ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dual_token_bucket_limiter_core regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        probe_row_t  row;
        verdict_t    typed_v;
        logic [31:0] rate_plan [0:PHASE_N-1];
        logic [31:0] clock_ms;
        logic [31:0] nbytes;
        logic [2:0]  op;
        int unsigned pick;
        int unsigned span;

        // Columns: is_cfg, typed, op, now_ms, nbytes, allowed, tx_used, rx_used
        probes = '{
            // fresh buckets are full: no usage, full-rate check passes, one more fails
            '{1'b0, 1'b1, OP_QUERY,     32'd0,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_TX,  32'd0,     32'd10485760, 1'b1, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_RX,  32'd0,     32'd10485761, 1'b0, 32'd0,        32'd0},
            // overdraw empties the bucket at zero
            '{1'b0, 1'b1, OP_RECORD_TX, 32'd0,     32'hFFFFFFFF, 1'b0, 32'd10485760, 32'd0},
            '{1'b0, 1'b1, OP_RECORD_RX, 32'd0,     32'd1000,     1'b0, 32'd10485760, 32'd1000},
            // unused codes change nothing, even with a far timestamp
            '{1'b0, 1'b1, OP_UNUSED_LO, 32'd12345, 32'd7,        1'b0, 32'd10485760, 32'd1000},
            '{1'b0, 1'b1, OP_UNUSED_HI, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd10485760, 32'd1000},
            '{1'b0, 1'b1, OP_CHECK_TX,  32'd0,     32'd0,        1'b1, 32'd10485760, 32'd1000},
            // partial refills
            '{1'b0, 1'b0, OP_CHECK_TX,  32'd1,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b0, OP_RECORD_TX, 32'd500,   32'd1,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b0, OP_QUERY,     32'd0,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b0, OP_CHECK_RX,  32'd1499,  32'd20000,    1'b0, 32'd0,        32'd0},
            // a full second refills both buckets to capacity
            '{1'b0, 1'b1, OP_RECORD_RX, 32'd2499,  32'd0,        1'b0, 32'd0,        32'd0},
            // rate lowered below the tokens: usage reads zero until a refill clamps
            '{1'b1, 1'b0, OP_QUERY,     32'd0,     32'd1000,     1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_QUERY,     32'd0,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_TX,  32'd2499,  32'd10485760, 1'b1, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_TX,  32'd2500,  32'd1001,     1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_RECORD_TX, 32'd2500,  32'd1000,     1'b0, 32'd1000,     32'd0},
            // backward timestamp wraps into a long gap
            '{1'b0, 1'b0, OP_RECORD_RX, 32'd2499,  32'd1,        1'b0, 32'd0,        32'd0},
            // widest rate
            '{1'b1, 1'b0, OP_QUERY,     32'd0,     32'hFFFFFFFF, 1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b0, OP_QUERY,     32'd0,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_RECORD_TX, 32'd3499,  32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 32'd0},
            // zero rate drains both buckets to nothing
            '{1'b1, 1'b0, OP_QUERY,     32'd0,     32'd0,        1'b0, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_RX,  32'd3500,  32'd0,        1'b1, 32'd0,        32'd0},
            '{1'b0, 1'b1, OP_CHECK_TX,  32'd3501,  32'd1,        1'b0, 32'd0,        32'd0},
            '{1'b1, 1'b0, OP_QUERY,     32'd0,     RATE_RESET,   1'b0, 32'd0,        32'd0}
        };

        rate_plan = '{RATE_RESET, 32'd1, 32'd999, 32'd1000, 32'd1001, 32'hFFFFFFFF,
                      32'd0, 32'd0, 32'd0, RATE_RESET};
        rate_plan[7] = $urandom();
        rate_plan[8] = $urandom_range(1, 100000);

        // Hold reset, then release it once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int i = 0; i < PROBE_N; i++) begin
            row = probes[i];
            if (row.is_cfg) begin
                write_rate(row.nbytes);
            end else begin
                typed_v = {row.allowed, row.tx_used, row.rx_used};
                push_request(row.op, row.now_ms, row.nbytes, row.typed, typed_v);
            end
        end

        // Random phases, one rate each
        clock_ms = 32'd4000;
        for (int ph = 0; ph < PHASE_N; ph++) begin
            write_rate(rate_plan[ph]);
            span = bkt_rate / 1000 * 4 + 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Mid-phase: hold the sender until the pipe is empty
                if (i == PHASE_ITEMS / 2)
                    drain_results();

                pick = $urandom_range(0, 99);
                if (pick < 8)
                    op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                else
                    op = 3'($urandom_range(OP_CHECK_TX, OP_QUERY));

                // Mostly small forward steps; some long, backward or wild stamps
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    clock_ms = clock_ms;
                else if (pick < 70)
                    clock_ms = clock_ms + $urandom_range(1, 3);
                else if (pick < 88)
                    clock_ms = clock_ms + $urandom_range(4, 1200);
                else if (pick < 94)
                    clock_ms = clock_ms - $urandom_range(1, 50);
                else if (pick < 97)
                    clock_ms = $urandom();
                else
                    clock_ms = 32'hFFFFFFFF - $urandom_range(0, 20);

                // Byte counts around the refill size, the rate, the extremes
                // and right at the current token level
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    nbytes = $urandom_range(0, span);
                else if (pick < 65)
                    nbytes = $urandom_range(0, bkt_rate);
                else if (pick < 80)
                    nbytes = $urandom();
                else if (pick < 86)
                    nbytes = 32'd0;
                else if (pick < 90)
                    nbytes = 32'hFFFFFFFF;
                else if (op == OP_CHECK_RX || op == OP_RECORD_RX)
                    nbytes = bkt_rx + $urandom_range(0, 2) - 1;
                else
                    nbytes = bkt_tx + $urandom_range(0, 2) - 1;

                push_request(op, clock_ms, nbytes, 1'b0, '0);
            end
        end

        // Wait out the pipe, then give the verdict
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("dual_token_bucket_limiter_core regression: pass");
        else
            $display("dual_token_bucket_limiter_core regression: fail");
        $finish;
    end

endmodule
